// ===== rtl/ils_pkg.sv =====
package ils_pkg;

    // Default sizes and the capacity loaded at reset.
    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 8;
    localparam int CAP_RESET      = 10;

    localparam int CMD_W  = 3;
    localparam int ST_W   = 3;
    localparam int STEP_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_WRITE  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(5);

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = ST_W'(0);
    localparam logic [ST_W-1:0] ST_EMPTY    = ST_W'(1);
    localparam logic [ST_W-1:0] ST_OOB      = ST_W'(2);
    localparam logic [ST_W-1:0] ST_FULL     = ST_W'(3);
    localparam logic [ST_W-1:0] ST_NOTFOUND = ST_W'(4);

    // Microprogram addresses.
    localparam logic [STEP_W-1:0] STP_IDLE     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STP_DISPATCH = STEP_W'(1);
    localparam logic [STEP_W-1:0] STP_A0       = STEP_W'(2);
    localparam logic [STEP_W-1:0] STP_A1       = STEP_W'(3);
    localparam logic [STEP_W-1:0] STP_R0       = STEP_W'(4);
    localparam logic [STEP_W-1:0] STP_R1       = STEP_W'(5);
    localparam logic [STEP_W-1:0] STP_R2       = STEP_W'(6);
    localparam logic [STEP_W-1:0] STP_W0       = STEP_W'(7);
    localparam logic [STEP_W-1:0] STP_W1       = STEP_W'(8);
    localparam logic [STEP_W-1:0] STP_W2       = STEP_W'(9);
    localparam logic [STEP_W-1:0] STP_S0       = STEP_W'(10);
    localparam logic [STEP_W-1:0] STP_S1       = STEP_W'(11);
    localparam logic [STEP_W-1:0] STP_S2       = STEP_W'(12);
    localparam logic [STEP_W-1:0] STP_S3       = STEP_W'(13);
    localparam logic [STEP_W-1:0] STP_S4       = STEP_W'(14);
    localparam logic [STEP_W-1:0] STP_I0       = STEP_W'(15);
    localparam logic [STEP_W-1:0] STP_I1       = STEP_W'(16);
    localparam logic [STEP_W-1:0] STP_I2       = STEP_W'(17);
    localparam logic [STEP_W-1:0] STP_I3       = STEP_W'(18);
    localparam logic [STEP_W-1:0] STP_I4       = STEP_W'(19);
    localparam logic [STEP_W-1:0] STP_D0       = STEP_W'(20);
    localparam logic [STEP_W-1:0] STP_D1       = STEP_W'(21);
    localparam logic [STEP_W-1:0] STP_D2       = STEP_W'(22);
    localparam logic [STEP_W-1:0] STP_D3       = STEP_W'(23);
    localparam logic [STEP_W-1:0] STP_D4       = STEP_W'(24);
    localparam logic [STEP_W-1:0] STP_E_EMPTY  = STEP_W'(25);
    localparam logic [STEP_W-1:0] STP_E_OOB    = STEP_W'(26);
    localparam logic [STEP_W-1:0] STP_E_FULL   = STEP_W'(27);
    localparam logic [STEP_W-1:0] STP_FIN      = STEP_W'(28);

    // Sequencing modes.
    localparam logic [1:0] SQ_NEXT     = 2'd0;
    localparam logic [1:0] SQ_DISPATCH = 2'd1;
    localparam logic [1:0] SQ_WAIT_IN  = 2'd2;
    localparam logic [1:0] SQ_FINISH   = 2'd3;

    // Branch conditions.
    localparam logic [3:0] C_NEVER        = 4'd0;
    localparam logic [3:0] C_ALWAYS       = 4'd1;
    localparam logic [3:0] C_FULL         = 4'd2;
    localparam logic [3:0] C_EMPTY        = 4'd3;
    localparam logic [3:0] C_IDX_GE_CNT   = 4'd4;
    localparam logic [3:0] C_IDX_GT_CNT   = 4'd5;
    localparam logic [3:0] C_HIT          = 4'd6;
    localparam logic [3:0] C_MATCH_OR_END = 4'd7;
    localparam logic [3:0] C_RPTR_GE_CNT  = 4'd8;
    localparam logic [3:0] C_WPTR_LE_IDX1 = 4'd9;

    // Datapath selects and pointer operations.
    localparam logic       RA_RPTR = 1'b0;
    localparam logic       RA_IDX  = 1'b1;
    localparam logic [1:0] WA_WPTR = 2'd0;
    localparam logic [1:0] WA_IDX  = 2'd1;
    localparam logic [1:0] WA_CNT  = 2'd2;
    localparam logic       WD_VAL   = 1'b0;
    localparam logic       WD_RDATA = 1'b1;

    localparam logic [2:0] RP_HOLD   = 3'd0;
    localparam logic [2:0] RP_INC    = 3'd1;
    localparam logic [2:0] RP_DEC    = 3'd2;
    localparam logic [2:0] RP_ZERO   = 3'd3;
    localparam logic [2:0] RP_CNT_M1 = 3'd4;
    localparam logic [2:0] RP_IDX_P1 = 3'd5;

    localparam logic [2:0] WP_HOLD = 3'd0;
    localparam logic [2:0] WP_INC  = 3'd1;
    localparam logic [2:0] WP_DEC  = 3'd2;
    localparam logic [2:0] WP_CNT  = 3'd3;
    localparam logic [2:0] WP_IDX  = 3'd4;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // One microinstruction. An all-zero word does nothing and falls through.
    typedef struct packed {
        logic [1:0]        seq_mode;
        logic [3:0]        cond;
        logic              cond_inv;
        logic [STEP_W-1:0] target;
        logic              re;
        logic              ra_sel;
        logic              we;
        logic [1:0]        wa_sel;
        logic              wd_sel;
        logic [2:0]        rp_op;
        logic [2:0]        wp_op;
        logic [1:0]        cnt_op;
        logic              st_we;
        logic [ST_W-1:0]   st_val;
        logic              data_we;
        logic              cmp_we;
        logic              clr;
        logic              out_ld;
    } ctl_word_t;

    // Conditions reported by the datapath to the sequencer.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             idx_ge_cnt;
        logic             idx_gt_cnt;
        logic             hit;
        logic             match_or_end;
        logic             rptr_ge_cnt;
        logic             wptr_le_idx1;
        logic             out_free;
    } dp_flags_t;

    function automatic logic [STEP_W-1:0] dispatch_entry(input logic [CMD_W-1:0] cmd);
        logic [STEP_W-1:0] s;
        case (cmd)
            CMD_APPEND: s = STP_A0;
            CMD_READ:   s = STP_R0;
            CMD_WRITE:  s = STP_W0;
            CMD_SEARCH: s = STP_S0;
            CMD_INSERT: s = STP_I0;
            CMD_DELETE: s = STP_D0;
            default:    s = STP_FIN;
        endcase
        return s;
    endfunction

    // The microprogram.
    function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '0;
        case (step)
            STP_IDLE:
            begin
                w.seq_mode = SQ_WAIT_IN;
                w.clr      = 1'b1;
                w.st_we    = 1'b1;
                w.st_val   = ST_OK;
            end
            STP_DISPATCH:
            begin
                w.seq_mode = SQ_DISPATCH;
            end
            STP_A0:
            begin
                w.cond   = C_FULL;
                w.target = STP_E_FULL;
            end
            STP_A1:
            begin
                w.we     = 1'b1;
                w.wa_sel = WA_CNT;
                w.wd_sel = WD_VAL;
                w.cnt_op = CNT_INC;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_R0, STP_W0, STP_D0:
            begin
                w.cond   = C_EMPTY;
                w.target = STP_E_EMPTY;
            end
            STP_R1:
            begin
                w.cond   = C_IDX_GE_CNT;
                w.target = STP_E_OOB;
                w.re     = 1'b1;
                w.ra_sel = RA_IDX;
            end
            STP_R2:
            begin
                w.data_we = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = STP_FIN;
            end
            STP_W1:
            begin
                w.cond   = C_IDX_GE_CNT;
                w.target = STP_E_OOB;
            end
            STP_W2:
            begin
                w.we     = 1'b1;
                w.wa_sel = WA_IDX;
                w.wd_sel = WD_VAL;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_S0:
            begin
                w.cond   = C_EMPTY;
                w.target = STP_E_EMPTY;
                w.rp_op  = RP_ZERO;
            end
            STP_S1:
            begin
                w.re     = 1'b1;
                w.ra_sel = RA_RPTR;
                w.rp_op  = RP_INC;
            end
            STP_S2:
            begin
                w.cmp_we   = 1'b1;
                w.re       = 1'b1;
                w.ra_sel   = RA_RPTR;
                w.rp_op    = RP_INC;
                w.cond     = C_MATCH_OR_END;
                w.cond_inv = 1'b1;
                w.target   = STP_S2;
            end
            STP_S3:
            begin
                w.cond   = C_HIT;
                w.target = STP_FIN;
            end
            STP_S4:
            begin
                w.clr    = 1'b1;
                w.st_we  = 1'b1;
                w.st_val = ST_NOTFOUND;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_I0:
            begin
                w.cond   = C_IDX_GT_CNT;
                w.target = STP_E_OOB;
            end
            STP_I1:
            begin
                w.cond   = C_FULL;
                w.target = STP_E_FULL;
                w.wp_op  = WP_CNT;
                w.rp_op  = RP_CNT_M1;
            end
            STP_I2:
            begin
                w.cond   = C_IDX_GE_CNT;
                w.target = STP_I4;
                w.re     = 1'b1;
                w.ra_sel = RA_RPTR;
                w.rp_op  = RP_DEC;
            end
            STP_I3:
            begin
                w.we       = 1'b1;
                w.wa_sel   = WA_WPTR;
                w.wd_sel   = WD_RDATA;
                w.wp_op    = WP_DEC;
                w.re       = 1'b1;
                w.ra_sel   = RA_RPTR;
                w.rp_op    = RP_DEC;
                w.cond     = C_WPTR_LE_IDX1;
                w.cond_inv = 1'b1;
                w.target   = STP_I3;
            end
            STP_I4:
            begin
                w.we     = 1'b1;
                w.wa_sel = WA_IDX;
                w.wd_sel = WD_VAL;
                w.cnt_op = CNT_INC;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_D1:
            begin
                w.cond   = C_IDX_GE_CNT;
                w.target = STP_E_OOB;
                w.wp_op  = WP_IDX;
                w.rp_op  = RP_IDX_P1;
            end
            STP_D2:
            begin
                w.cond   = C_RPTR_GE_CNT;
                w.target = STP_D4;
                w.re     = 1'b1;
                w.ra_sel = RA_RPTR;
                w.rp_op  = RP_INC;
            end
            STP_D3:
            begin
                w.we       = 1'b1;
                w.wa_sel   = WA_WPTR;
                w.wd_sel   = WD_RDATA;
                w.wp_op    = WP_INC;
                w.re       = 1'b1;
                w.ra_sel   = RA_RPTR;
                w.rp_op    = RP_INC;
                w.cond     = C_RPTR_GE_CNT;
                w.cond_inv = 1'b1;
                w.target   = STP_D3;
            end
            STP_D4:
            begin
                w.cnt_op = CNT_DEC;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_E_EMPTY:
            begin
                w.st_we  = 1'b1;
                w.st_val = ST_EMPTY;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_E_OOB:
            begin
                w.st_we  = 1'b1;
                w.st_val = ST_OOB;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_E_FULL:
            begin
                w.st_we  = 1'b1;
                w.st_val = ST_FULL;
                w.cond   = C_ALWAYS;
                w.target = STP_FIN;
            end
            STP_FIN:
            begin
                w.seq_mode = SQ_FINISH;
                w.out_ld   = 1'b1;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ils_seq.sv =====
// Microprogram sequencer: step counter, control store and branch logic.
module ils_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  ils_pkg::dp_flags_t                flags,
    output ils_pkg::ctl_word_t                ctl,
    output logic                              busy
);

    logic [ils_pkg::STEP_W-1:0] step_reg;
    logic [ils_pkg::STEP_W-1:0] step_next;
    logic                       cond_val;
    logic                       taken;

    assign ctl  = ils_pkg::ucode_rom(step_reg);
    assign busy = (step_reg != ils_pkg::STP_IDLE);

    always_comb
    begin
        case (ctl.cond)
            ils_pkg::C_ALWAYS:       cond_val = 1'b1;
            ils_pkg::C_FULL:         cond_val = flags.full;
            ils_pkg::C_EMPTY:        cond_val = flags.empty;
            ils_pkg::C_IDX_GE_CNT:   cond_val = flags.idx_ge_cnt;
            ils_pkg::C_IDX_GT_CNT:   cond_val = flags.idx_gt_cnt;
            ils_pkg::C_HIT:          cond_val = flags.hit;
            ils_pkg::C_MATCH_OR_END: cond_val = flags.match_or_end;
            ils_pkg::C_RPTR_GE_CNT:  cond_val = flags.rptr_ge_cnt;
            ils_pkg::C_WPTR_LE_IDX1: cond_val = flags.wptr_le_idx1;
            default:                 cond_val = 1'b0;
        endcase
        taken = cond_val ^ ctl.cond_inv;
    end

    always_comb
    begin
        case (ctl.seq_mode)
            ils_pkg::SQ_WAIT_IN:
                step_next = accept ? ils_pkg::STP_DISPATCH : step_reg;
            ils_pkg::SQ_DISPATCH:
                step_next = ils_pkg::dispatch_entry(flags.cmd);
            ils_pkg::SQ_FINISH:
                step_next = flags.out_free ? ils_pkg::STP_IDLE : step_reg;
            default:
                step_next = taken ? ctl.target : step_reg + ils_pkg::STEP_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ils_pkg::STP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/ils_dp.sv =====
// Datapath: entry memory, pointers, count, capacity and result registers.
module ils_dp #(
    parameter int DEPTH      = ils_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = ils_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int POS_W     = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ils_pkg::ctl_word_t        ctl,
    input  logic                      accept,
    input  logic [ils_pkg::CMD_W-1:0] cmd_in,
    input  logic [CNT_W-1:0]          index_in,
    input  logic [ITEM_WIDTH-1:0]     value_in,
    input  logic                      cfg_we,
    input  logic [CNT_W-1:0]          cfg_data,
    output ils_pkg::dp_flags_t        flags,
    input  logic                      rsp_stall,
    output logic                      rsp_valid,
    output logic [ils_pkg::ST_W-1:0]  rsp_status,
    output logic [ITEM_WIDTH-1:0]     rsp_data,
    output logic [POS_W-1:0]          rsp_position,
    output logic [CNT_W-1:0]          rsp_count,
    output logic                      rsp_is_empty,
    output logic                      rsp_is_full
);

    localparam int CAP_RST = (ils_pkg::CAP_RESET > DEPTH) ? DEPTH : ils_pkg::CAP_RESET;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];

    logic [ils_pkg::CMD_W-1:0] cmd_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [ITEM_WIDTH-1:0]     val_reg;
    logic [ITEM_WIDTH-1:0]     rdata_reg;
    logic [ITEM_WIDTH-1:0]     data_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      hit_reg;

    logic [CNT_W-1:0]          cap_reg, cap_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          rptr_reg, rptr_next;
    logic [CNT_W-1:0]          wptr_reg, wptr_next;
    logic [ils_pkg::ST_W-1:0]  status_reg, status_next;
    logic                      rsp_valid_reg, rsp_valid_next;

    logic [ils_pkg::ST_W-1:0]  rsp_status_reg;
    logic [ITEM_WIDTH-1:0]     rsp_data_reg;
    logic [POS_W-1:0]          rsp_pos_reg;
    logic [CNT_W-1:0]          rsp_count_reg;
    logic                      rsp_empty_reg;
    logic                      rsp_full_reg;

    logic [CNT_W-1:0]          cap_eff;
    logic                      full;
    logic                      match;
    logic                      out_free;
    logic                      load;
    logic [CNT_W-1:0]          rptr_m1;
    logic [CNT_W:0]            idx_p1_wide;
    logic [POS_W-1:0]          raddr;
    logic [POS_W-1:0]          waddr;
    logic [ITEM_WIDTH-1:0]     wdata;

    // A capacity of zero acts as one, and anything above the depth as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = ONE_C;
        end
        else if (cap_reg > DEPTH_C)
        begin
            cap_eff = DEPTH_C;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign full        = (count_reg >= cap_eff);
    assign match       = (rdata_reg == val_reg);
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign load        = ctl.out_ld && out_free;
    assign rptr_m1     = rptr_reg - ONE_C;
    assign idx_p1_wide = {1'b0, idx_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        flags.cmd          = cmd_reg;
        flags.full         = full;
        flags.empty        = (count_reg == '0);
        flags.idx_ge_cnt   = (idx_reg >= count_reg);
        flags.idx_gt_cnt   = (idx_reg > count_reg);
        flags.hit          = hit_reg;
        flags.match_or_end = match || (rptr_reg >= count_reg);
        flags.rptr_ge_cnt  = (rptr_reg >= count_reg);
        flags.wptr_le_idx1 = ({1'b0, wptr_reg} <= idx_p1_wide);
        flags.out_free     = out_free;
    end

    assign raddr = (ctl.ra_sel == ils_pkg::RA_IDX) ? idx_reg[POS_W-1:0] : rptr_reg[POS_W-1:0];
    assign wdata = (ctl.wd_sel == ils_pkg::WD_RDATA) ? rdata_reg : val_reg;

    always_comb
    begin
        case (ctl.wa_sel)
            ils_pkg::WA_IDX: waddr = idx_reg[POS_W-1:0];
            ils_pkg::WA_CNT: waddr = count_reg[POS_W-1:0];
            default:         waddr = wptr_reg[POS_W-1:0];
        endcase
    end

    always_comb
    begin
        case (ctl.rp_op)
            ils_pkg::RP_INC:    rptr_next = rptr_reg + ONE_C;
            ils_pkg::RP_DEC:    rptr_next = rptr_m1;
            ils_pkg::RP_ZERO:   rptr_next = '0;
            ils_pkg::RP_CNT_M1: rptr_next = count_reg - ONE_C;
            ils_pkg::RP_IDX_P1: rptr_next = idx_p1_wide[CNT_W-1:0];
            default:            rptr_next = rptr_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.wp_op)
            ils_pkg::WP_INC: wptr_next = wptr_reg + ONE_C;
            ils_pkg::WP_DEC: wptr_next = wptr_reg - ONE_C;
            ils_pkg::WP_CNT: wptr_next = count_reg;
            ils_pkg::WP_IDX: wptr_next = idx_reg;
            default:         wptr_next = wptr_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.cnt_op)
            ils_pkg::CNT_INC: count_next = count_reg + ONE_C;
            ils_pkg::CNT_DEC: count_next = count_reg - ONE_C;
            default:          count_next = count_reg;
        endcase
    end

    assign cap_next       = cfg_we ? cfg_data : cap_reg;
    assign status_next    = ctl.st_we ? ctl.st_val : status_reg;
    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CNT_W'(CAP_RST);
            count_reg     <= '0;
            status_reg    <= ils_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rptr_reg <= rptr_next;
        wptr_reg <= wptr_next;
        if (accept)
        begin
            cmd_reg <= cmd_in;
            idx_reg <= index_in;
            val_reg <= value_in;
        end
        if (ctl.clr)
        begin
            data_reg <= '0;
            pos_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.data_we)
            begin
                data_reg <= rdata_reg;
            end
            if (ctl.cmp_we)
            begin
                pos_reg <= rptr_m1[POS_W-1:0];
                hit_reg <= match;
            end
        end
        if (load)
        begin
            rsp_status_reg <= status_reg;
            rsp_data_reg   <= data_reg;
            rsp_pos_reg    <= hit_reg ? pos_reg : '0;
            rsp_count_reg  <= count_reg;
            rsp_empty_reg  <= (count_reg == '0);
            rsp_full_reg   <= full;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_status   = rsp_status_reg;
    assign rsp_data     = rsp_data_reg;
    assign rsp_position = rsp_pos_reg;
    assign rsp_count    = rsp_count_reg;
    assign rsp_is_empty = rsp_empty_reg;
    assign rsp_is_full  = rsp_full_reg;

endmodule

// ===== rtl/indexed_list_store.sv =====
// Read, write and append words run a short path through the microprogram; search, insert
// and delete walk the list and run longer the more entries they visit. One word is handled
// at a time: the next word is taken once the previous result is stored in the output register.
// The walk over the list is set by the single read port of the entry memory, one entry a cycle.
// Reset clears the entry count, sets the capacity to 10 (DEPTH if less) and empties the
// output register; the entry memory is not cleared, so there is no clearing pass after reset.
module indexed_list_store #(
    parameter int DEPTH      = ils_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = ils_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int POS_W     = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,

    // Command channel.
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic [ils_pkg::CMD_W-1:0] cmd,
    input  logic [CNT_W-1:0]          index,
    input  logic [ITEM_WIDTH-1:0]     value,

    // Result channel.
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [ils_pkg::ST_W-1:0]  status,
    output logic [ITEM_WIDTH-1:0]     data,
    output logic [POS_W-1:0]          position,
    output logic [CNT_W-1:0]          count,
    output logic                      is_empty,
    output logic                      is_full,

    // Capacity register write port.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CNT_W-1:0]          capacity_limit
);

    // The sequencer steps through a short microprogram for each command word. Each
    // step drives the datapath (memory read and write, pointer updates, count update,
    // status capture) and may branch on a condition that the datapath reports.
    // Shifts for insert and delete are pipelined: the word read in one step is
    // written one place up or down in the next, while the following word is read.
    // Results are held in an output register, so the sequencer only waits at its
    // final step when a previous result has not yet been taken.

    ils_pkg::ctl_word_t ctl;
    ils_pkg::dp_flags_t flags;
    logic               busy;
    logic               accept;
    logic               cfg_we;

    // Always writable: the user must write only while the block is idle; it is not enforced.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // A new command word is taken only while the sequencer sits in its idle step.
    assign cmd_stall = busy;
    assign accept    = cmd_valid && !cmd_stall;

    ils_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .flags  (flags),
        .ctl    (ctl),
        .busy   (busy)
    );

    ils_dp #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .accept       (accept),
        .cmd_in       (cmd),
        .index_in     (index),
        .value_in     (value),
        .cfg_we       (cfg_we),
        .cfg_data     (capacity_limit),
        .flags        (flags),
        .rsp_stall    (rsp_stall),
        .rsp_valid    (rsp_valid),
        .rsp_status   (status),
        .rsp_data     (data),
        .rsp_position (position),
        .rsp_count    (count),
        .rsp_is_empty (is_empty),
        .rsp_is_full  (is_full)
    );

    // Taking a word moves the sequencer out of its idle step.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_stall)
        else $error("sequencer stayed idle after taking a command word");

    // A new result appears only at the end of a command's microprogram.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result appeared without a command in progress");

    // A refusal for lack of room is only given when the list is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ils_pkg::ST_FULL)) |-> is_full)
        else $error("full status reported on a list that is not full");

    // An empty status is only given when the list holds no entries.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ils_pkg::ST_EMPTY)) |-> (is_empty && (count == '0)))
        else $error("empty status reported on a list that holds entries");

endmodule
